### src/tppp_pkg.sv
// ----------------------------------------------------------------------------
// tppp_pkg
// Shared constants, types and the arctangent table for the two-plane track
// projection block.
// ----------------------------------------------------------------------------
package tppp_pkg;

  // Default geometry of the datapath.
  localparam int POS_WIDTH_DEF     = 24;
  localparam int CORDIC_STAGES_DEF = 16;

  // Configuration register widths.
  localparam int ROT_W   = 18;
  localparam int SHIFT_W = 24;
  localparam int RATIO_W = 20;
  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 3;

  // Angle arithmetic: internal accumulator and output field widths.
  localparam int ANGLE_W   = 19;
  localparam int ZW        = 21;
  localparam int GUARD_BITS = 2;

  localparam logic signed [ZW-1:0] PI_Q16   = ZW'(205887);
  localparam logic [23:0]          GAIN_Q24 = 24'd10188014;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROT_COS      = 3'd0,
    REG_ROT_SIN      = 3'd1,
    REG_SHIFT_X      = 3'd2,
    REG_SHIFT_Y      = 3'd3,
    REG_EXTRAP_RATIO = 3'd4
  } cfg_reg_t;

  // Arctangent of 2^-i in Q2.16 radians.
  function automatic logic signed [ZW-1:0] atan_q16(input int idx);
    logic signed [ZW-1:0] val;
    case (idx)
      0:       val = ZW'(51472);
      1:       val = ZW'(30386);
      2:       val = ZW'(16055);
      3:       val = ZW'(8150);
      4:       val = ZW'(4091);
      5:       val = ZW'(2047);
      6:       val = ZW'(1024);
      7:       val = ZW'(512);
      8:       val = ZW'(256);
      9:       val = ZW'(128);
      10:      val = ZW'(64);
      11:      val = ZW'(32);
      12:      val = ZW'(16);
      13:      val = ZW'(8);
      14:      val = ZW'(4);
      15:      val = ZW'(2);
      16:      val = ZW'(1);
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

### src/tppp_cordic_stage.sv
// ----------------------------------------------------------------------------
// tppp_cordic_stage
// One registered vectoring iteration of the CORDIC: rotates the vector
// toward the positive x axis by the arctangent of 2^-IDX.
// ----------------------------------------------------------------------------
module tppp_cordic_stage
  import tppp_pkg::*;
#(
  parameter int CW  = 40,
  parameter int IDX = 0
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [CW-1:0] x_i,
  input  logic signed [CW-1:0] y_i,
  input  logic signed [ZW-1:0] z_i,
  output logic signed [CW-1:0] x_o,
  output logic signed [CW-1:0] y_o,
  output logic signed [ZW-1:0] z_o
);

  localparam logic signed [ZW-1:0] ATAN = atan_q16(IDX);

  logic signed [CW-1:0] x_r, y_r, x_nxt, y_nxt, dx, dy;
  logic signed [ZW-1:0] z_r, z_nxt;

  always_comb begin
    dx = y_i >>> IDX;
    dy = x_i >>> IDX;
    if (!y_i[CW-1]) begin
      x_nxt = x_i + dx;
      y_nxt = y_i - dy;
      z_nxt = z_i + ATAN;
    end else begin
      x_nxt = x_i - dx;
      y_nxt = y_i + dy;
      z_nxt = z_i - ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign x_o = x_r;
  assign y_o = y_r;
  assign z_o = z_r;

endmodule

### src/two_plane_track_projection_polar.sv
// Throughput: one beat per cycle while the output is accepted or a stage
// is empty; every stage of the unrolled pipeline, one register per CORDIC
// iteration included, takes a new beat each cycle that it is enabled.
// Reset (rst_n low, synchronous) empties the pipeline and loads the
// alignment registers with the identity rotation, zero shift and ratio 1.0.
// ----------------------------------------------------------------------------
// two_plane_track_projection_polar
// Aligns an upper and a lower hit with a rotation and a shift, extends the
// straight track to a target plane and reports the projected point in
// Cartesian and polar form.
// ----------------------------------------------------------------------------
module two_plane_track_projection_polar
  import tppp_pkg::*;
#(
  parameter int POS_WIDTH     = POS_WIDTH_DEF,
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic clk,
  input  logic rst_n,

  // Input stream.
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // Fields from bit 0 up: upper_x, upper_y, lower_x, lower_y, zero padding.
  input  logic [((4*POS_WIDTH+7)/8)*8-1:0]     in_tdata,

  // Result stream.
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // Fields from bit 0 up: proj_x, proj_y, proj_radius, proj_angle, zero padding.
  output logic [((3*POS_WIDTH+18+7)/8)*8-1:0]  out_tdata,

  // Configuration write channel.
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [CFG_IDX_W-1:0]                 cfg_index,
  input  logic [CFG_DATA_W-1:0]                cfg_data
);

  // --------------------------------------------------------------------------
  // Widths. Products and sums keep their full range until the final
  // saturation, so every intermediate width follows from POS_WIDTH.
  // --------------------------------------------------------------------------
  localparam int P      = POS_WIDTH;
  localparam int N      = CORDIC_STAGES;
  localparam int IN_W   = ((4*P+7)/8)*8;
  localparam int OUT_W  = ((3*P+18+7)/8)*8;
  localparam int FLD_W  = 3*P + ANGLE_W - 1;     // packed result fields
  localparam int PRW    = P + ROT_W;              // rotation product
  localparam int SUMW   = PRW + 1;                // sum of two products
  localparam int AW     = ((P + 3 > SHIFT_W) ? P + 3 : SHIFT_W) + 1; // aligned
  localparam int DW     = AW + 1;                 // upper minus lower
  localparam int EPW    = DW + RATIO_W + 1;       // extrapolation product
  localparam int PW     = EPW - 15;               // projected point
  localparam int CW     = PW + GUARD_BITS + 3;    // CORDIC vector
  localparam int RPW    = P + 27;                 // radius gain product
  localparam int NS     = N + 8;                  // pipeline register stages

  // Stage positions in the valid chain.
  localparam int ST_PREP = 5;
  localparam int ST_RAD  = ST_PREP + N + 1;
  localparam int ST_OUT  = NS - 1;

  localparam logic signed [SUMW-1:0] HALF_ROT = SUMW'(32768);
  localparam logic signed [EPW-1:0]  HALF_EXT = EPW'(32768);
  localparam logic [RPW-1:0]         HALF_RAD = RPW'(1) << 25;

  // --------------------------------------------------------------------------
  // Configuration registers, read directly by the datapath. Writes must arrive
  // only while the pipeline is idle (not enforced). Unknown indexes are ignored.
  // --------------------------------------------------------------------------
  logic signed [ROT_W-1:0]   rot_cos_r, rot_sin_r;
  logic signed [SHIFT_W-1:0] shift_x_r, shift_y_r;
  logic [RATIO_W-1:0]        extrap_ratio_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_cos_r      <= ROT_W'(65536);
      rot_sin_r      <= '0;
      shift_x_r      <= '0;
      shift_y_r      <= '0;
      extrap_ratio_r <= RATIO_W'(65536);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_ROT_COS:      rot_cos_r      <= cfg_data[ROT_W-1:0];
        REG_ROT_SIN:      rot_sin_r      <= cfg_data[ROT_W-1:0];
        REG_SHIFT_X:      shift_x_r      <= cfg_data[SHIFT_W-1:0];
        REG_SHIFT_Y:      shift_y_r      <= cfg_data[SHIFT_W-1:0];
        REG_EXTRAP_RATIO: extrap_ratio_r <= cfg_data[RATIO_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline flow control. A stage loads when it is empty or when the stage
  // after it loads, so bubbles close up and the input keeps flowing while a
  // finished result waits in the output register.
  // --------------------------------------------------------------------------
  logic [NS-1:0] v_r;
  logic [NS-1:0] en;

  always_comb begin
    en[NS-1] = !v_r[NS-1] || out_tready;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_tready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_tvalid;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 0: the eight rotation products of both hits.
  // --------------------------------------------------------------------------
  logic signed [P-1:0] ux, uy, lx, ly;

  assign ux = in_tdata[P-1:0];
  assign uy = in_tdata[2*P-1:P];
  assign lx = in_tdata[3*P-1:2*P];
  assign ly = in_tdata[4*P-1:3*P];

  logic signed [PRW-1:0] uxc_r, uys_r, uyc_r, uxs_r;
  logic signed [PRW-1:0] lxc_r, lys_r, lyc_r, lxs_r;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      uxc_r <= PRW'(ux) * PRW'(rot_cos_r);
      uys_r <= PRW'(uy) * PRW'(rot_sin_r);
      uyc_r <= PRW'(uy) * PRW'(rot_cos_r);
      uxs_r <= PRW'(ux) * PRW'(rot_sin_r);
      lxc_r <= PRW'(lx) * PRW'(rot_cos_r);
      lys_r <= PRW'(ly) * PRW'(rot_sin_r);
      lyc_r <= PRW'(ly) * PRW'(rot_cos_r);
      lxs_r <= PRW'(lx) * PRW'(rot_sin_r);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: sum, round the Q.26 result back to Q.10 (halves go up) and add
  // the alignment shift.
  // --------------------------------------------------------------------------
  logic signed [SUMW-1:0] s_ux, s_uy, s_lx, s_ly;
  logic signed [AW-1:0]   aux_r, auy_r, alx_r, aly_r;

  always_comb begin
    s_ux = (SUMW'(uxc_r) + SUMW'(uys_r) + HALF_ROT) >>> 16;
    s_uy = (SUMW'(uyc_r) - SUMW'(uxs_r) + HALF_ROT) >>> 16;
    s_lx = (SUMW'(lxc_r) + SUMW'(lys_r) + HALF_ROT) >>> 16;
    s_ly = (SUMW'(lyc_r) - SUMW'(lxs_r) + HALF_ROT) >>> 16;
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      aux_r <= AW'(s_ux) + AW'(shift_x_r);
      auy_r <= AW'(s_uy) + AW'(shift_y_r);
      alx_r <= AW'(s_lx) + AW'(shift_x_r);
      aly_r <= AW'(s_ly) + AW'(shift_y_r);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: track direction from the lower to the upper hit.
  // --------------------------------------------------------------------------
  logic signed [DW-1:0] dirx_r, diry_r;
  logic signed [AW-1:0] base2x_r, base2y_r;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      dirx_r   <= DW'(aux_r) - DW'(alx_r);
      diry_r   <= DW'(auy_r) - DW'(aly_r);
      base2x_r <= alx_r;
      base2y_r <= aly_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: scale the direction by the plane distance ratio.
  // --------------------------------------------------------------------------
  logic signed [EPW-1:0] extx_r, exty_r;
  logic signed [AW-1:0]  base3x_r, base3y_r;
  logic signed [RATIO_W:0] ratio_s;

  assign ratio_s = $signed({1'b0, extrap_ratio_r});

  always_ff @(posedge clk) begin
    if (en[3]) begin
      extx_r   <= EPW'(dirx_r) * EPW'(ratio_s);
      exty_r   <= EPW'(diry_r) * EPW'(ratio_s);
      base3x_r <= base2x_r;
      base3y_r <= base2y_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: projected point, still unsaturated.
  // --------------------------------------------------------------------------
  logic signed [EPW-1:0] rx, ry;
  logic signed [PW-1:0]  px_r, py_r;

  always_comb begin
    rx = (extx_r + HALF_EXT) >>> 16;
    ry = (exty_r + HALF_EXT) >>> 16;
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      px_r <= PW'(base3x_r) + PW'(rx);
      py_r <= PW'(base3y_r) + PW'(ry);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: saturate the Cartesian outputs and set up the CORDIC. Points in
  // the left half plane are turned by pi first, with the starting angle
  // taking the sign of y. The origin is flagged so its angle reads as zero.
  // --------------------------------------------------------------------------
  logic signed [CW-1:0] x0, y0;
  logic [P-1:0]         satx, saty;

  always_comb begin
    x0 = CW'(px_r) <<< GUARD_BITS;
    y0 = CW'(py_r) <<< GUARD_BITS;
    if (px_r[PW-1:P-1] == '0 || px_r[PW-1:P-1] == '1) begin
      satx = px_r[P-1:0];
    end else begin
      satx = {px_r[PW-1], {(P-1){~px_r[PW-1]}}};
    end
    if (py_r[PW-1:P-1] == '0 || py_r[PW-1:P-1] == '1) begin
      saty = py_r[P-1:0];
    end else begin
      saty = {py_r[PW-1], {(P-1){~py_r[PW-1]}}};
    end
  end

  logic signed [CW-1:0] cx [N+1];
  logic signed [CW-1:0] cy [N+1];
  logic signed [ZW-1:0] cz [N+1];
  logic signed [CW-1:0] x_prep_r, y_prep_r;
  logic signed [ZW-1:0] z_prep_r;

  // Side data that rides along the CORDIC stages.
  logic [P-1:0] projx_r [N+1];
  logic [P-1:0] projy_r [N+1];
  logic         origin_r [N+1];

  always_ff @(posedge clk) begin
    if (en[ST_PREP]) begin
      if (px_r[PW-1]) begin
        x_prep_r <= -x0;
        y_prep_r <= -y0;
        z_prep_r <= py_r[PW-1] ? -PI_Q16 : PI_Q16;
      end else begin
        x_prep_r <= x0;
        y_prep_r <= y0;
        z_prep_r <= '0;
      end
      projx_r[0]  <= satx;
      projy_r[0]  <= saty;
      origin_r[0] <= (px_r == '0) && (py_r == '0);
    end
  end

  assign cx[0] = x_prep_r;
  assign cy[0] = y_prep_r;
  assign cz[0] = z_prep_r;

  // --------------------------------------------------------------------------
  // CORDIC vectoring, one registered iteration per stage.
  // --------------------------------------------------------------------------
  for (genvar i = 0; i < N; i++) begin : g_cordic
    tppp_cordic_stage #(
      .CW  (CW),
      .IDX (i)
    ) u_stage (
      .clk (clk),
      .en  (en[ST_PREP+1+i]),
      .x_i (cx[i]),
      .y_i (cy[i]),
      .z_i (cz[i]),
      .x_o (cx[i+1]),
      .y_o (cy[i+1]),
      .z_o (cz[i+1])
    );

    always_ff @(posedge clk) begin
      if (en[ST_PREP+1+i]) begin
        projx_r[i+1]  <= projx_r[i];
        projy_r[i+1]  <= projy_r[i];
        origin_r[i+1] <= origin_r[i];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Radius stage: remove the CORDIC gain with one multiply and clamp the
  // angle to plus or minus pi. A vector beyond the guard range saturates.
  // --------------------------------------------------------------------------
  logic signed [CW-1:0] xf;
  logic signed [ZW-1:0] zf;
  logic                 rsat_nxt;

  logic [RPW-1:0]       rprod_r;
  logic                 rsat_r;
  logic signed [ZW-1:0] ang_r;
  logic [P-1:0]         rprojx_r, rprojy_r;

  always_comb begin
    xf       = cx[N];
    zf       = origin_r[N] ? '0 : cz[N];
    rsat_nxt = xf > $signed({{(CW-P-3){1'b0}}, 1'b1, {(P+2){1'b0}}});
  end

  always_ff @(posedge clk) begin
    if (en[ST_RAD]) begin
      rprod_r  <= RPW'(xf[P+2:0]) * RPW'(GAIN_Q24);
      rsat_r   <= rsat_nxt;
      if (zf > PI_Q16) begin
        ang_r <= PI_Q16;
      end else if (zf < -PI_Q16) begin
        ang_r <= -PI_Q16;
      end else begin
        ang_r <= zf;
      end
      rprojx_r <= projx_r[N];
      rprojy_r <= projy_r[N];
    end
  end

  // --------------------------------------------------------------------------
  // Output register: round the radius to Q13.10, saturate it and pack.
  // --------------------------------------------------------------------------
  logic [RPW-1:0]   rround;
  logic [P-2:0]     radius;
  logic [FLD_W-1:0] fields;
  logic [OUT_W-1:0] out_data_r;

  always_comb begin
    rround = (rprod_r + HALF_RAD) >> 26;
    if (rsat_r || (rround[RPW-1:P-1] != '0)) begin
      radius = '1;
    end else begin
      radius = rround[P-2:0];
    end
    fields = {ang_r[ANGLE_W-1:0], radius, rprojy_r, rprojx_r};
  end

  always_ff @(posedge clk) begin
    if (en[ST_OUT]) begin
      out_data_r <= OUT_W'(fields);
    end
  end

  assign out_tvalid = v_r[ST_OUT];
  assign out_tdata  = out_data_r;

endmodule
